// ===== design/pcg_pkg.sv =====
// Shared types, codes and helpers for the PCG32 XSH-RR generator.
// No dependencies; every other design file depends on this package.
package pcg_pkg;

    localparam int STATE_W = 64;
    localparam int WORD_W  = 32;
    localparam int SEQ_W   = 63;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W   = 5;

    localparam logic [STATE_W-1:0] LCG_MULT = 64'd6364136223846793005;
    localparam logic [SEQ_W-1:0]   SEQ_RESET = 63'd1442695040888963407;

    localparam logic [CMD_W-1:0] CMD_RESEED  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RAW     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BOUNDED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEQ  = 2'd1;

    // multiplier operand pairs (state half x constant half)
    localparam logic [1:0] MUL_LL = 2'd0;
    localparam logic [1:0] MUL_HL = 2'd1;
    localparam logic [1:0] MUL_LH = 2'd2;

    // result source
    localparam logic [1:0] SRC_ZERO = 2'd0;
    localparam logic [1:0] SRC_WORD = 2'd1;
    localparam logic [1:0] SRC_REM  = 2'd2;

    typedef struct packed {
        logic       reseed_init;
        logic       seed_add;
        logic       word_capture;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       acc_load;
        logic       acc_add;
        logic       state_update;
        logic       div_start_thr;
        logic       div_start_word;
        logic       div_step;
        logic       thr_capture;
        logic       out_load;
        logic [1:0] out_sel;
    } pcg_ctrl_t;

    typedef struct packed {
        logic bound_zero;
        logic draw_ok;
    } pcg_stat_t;

    // XSH-RR output permutation of the old state
    function automatic logic [WORD_W-1:0] xsh_rr(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0]  x;
        logic [WORD_W-1:0]   mixed;
        logic [4:0]          rot;
        logic [2*WORD_W-1:0] dbl;
        x     = (s >> 18) ^ s;
        mixed = x[58:27];
        rot   = s[63:59];
        dbl   = {mixed, mixed} >> rot;
        return dbl[WORD_W-1:0];
    endfunction

endpackage

// ===== design/pcg_ifs.sv =====
// Handshake channel interfaces: request, response and register write.
// Depends on pcg_pkg for widths.
interface pcg_req_if;
    logic                       valid;
    logic                       ready;
    logic [pcg_pkg::CMD_W-1:0]  cmd;
    logic [pcg_pkg::WORD_W-1:0] bound;
    modport source (output valid, output cmd, output bound, input ready);
    modport sink   (input valid, input cmd, input bound, output ready);
endinterface

interface pcg_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [pcg_pkg::WORD_W-1:0] value;
    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface pcg_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pcg_pkg::CFG_IDX_W-1:0] index;
    logic [pcg_pkg::STATE_W-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/pcg_dpath.sv =====
// Datapath: LCG state and increment, shared 32x32 multiplier, restoring
// remainder unit, config registers and result register. Depends on pcg_pkg.
module pcg_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  pcg_pkg::pcg_ctrl_t ctrl,
    output pcg_pkg::pcg_stat_t stat,
    pcg_req_if.sink            req,
    pcg_rsp_if.source          rsp,
    pcg_cfg_if.sink            cfg
);
    import pcg_pkg::*;

    logic [STATE_W-1:0]   seed_reg;
    logic [SEQ_W-1:0]     seq_reg;
    logic [STATE_W-1:0]   state_reg;
    logic [STATE_W-1:0]   inc_reg;
    logic [STATE_W-1:0]   before_reg;
    logic [STATE_W-1:0]   prod_reg;
    logic [STATE_W-1:0]   acc_reg;
    logic [WORD_W-1:0]    word_reg;
    logic [WORD_W-1:0]    bound_reg;
    logic [WORD_W-1:0]    thr_reg;
    logic [WORD_W-1:0]    rem_reg;
    logic [WORD_W-1:0]    dvd_reg;
    logic [WORD_W-1:0]    value_reg;

    logic [WORD_W-1:0]    mul_a;
    logic [WORD_W-1:0]    mul_b;
    logic [WORD_W:0]      trial;
    logic [WORD_W-1:0]    rem_next;
    logic [WORD_W-1:0]    value_next;

    assign cfg.ready = 1'b1;
    assign rsp.value = value_reg;

    assign stat.bound_zero = (req.bound == '0);
    assign stat.draw_ok    = (word_reg >= thr_reg) || (state_reg == before_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            seq_reg  <= SEQ_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_SEED)
                seed_reg <= cfg.data;
            else if (cfg.index == REG_SEQ)
                seq_reg <= cfg.data[SEQ_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            inc_reg   <= '0;
        end
        else
        begin
            if (ctrl.reseed_init)
            begin
                inc_reg   <= {seq_reg, 1'b1};
                state_reg <= '0;
            end
            else if (ctrl.seed_add)
                state_reg <= state_reg + seed_reg;
            else if (ctrl.state_update)
                state_reg <= acc_reg + inc_reg;
        end
    end

    always_comb
    begin
        mul_a = (ctrl.mul_sel == MUL_HL) ? state_reg[63:32] : state_reg[31:0];
        mul_b = (ctrl.mul_sel == MUL_LH) ? LCG_MULT[63:32] : LCG_MULT[31:0];
    end

    // state * mult mod 2^64 from three 32x32 partial products
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
            prod_reg <= STATE_W'(mul_a) * STATE_W'(mul_b);
        if (ctrl.acc_load)
            acc_reg <= prod_reg;
        else if (ctrl.acc_add)
            acc_reg <= acc_reg + {prod_reg[31:0], 32'h0};
        if (ctrl.word_capture)
        begin
            word_reg   <= xsh_rr(state_reg);
            before_reg <= state_reg;
        end
    end

    // restoring remainder, one dividend bit per step
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[WORD_W-1]};
        rem_next = (trial >= {1'b0, bound_reg}) ? WORD_W'(trial - {1'b0, bound_reg})
                                                : trial[WORD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.div_start_thr)
        begin
            bound_reg <= req.bound;
            dvd_reg   <= WORD_W'(0) - req.bound;
            rem_reg   <= '0;
        end
        else if (ctrl.div_start_word)
        begin
            dvd_reg <= word_reg;
            rem_reg <= '0;
        end
        else if (ctrl.div_step)
        begin
            dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (ctrl.thr_capture)
            thr_reg <= rem_next;
    end

    always_comb
    begin
        unique case (ctrl.out_sel)
            SRC_WORD: value_next = word_reg;
            SRC_REM:  value_next = rem_reg;
            default:  value_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
            value_reg <= value_next;
    end

endmodule

// ===== design/pcg_ctrl.sv =====
// Controller: sequences reseed, LCG advance, rejection loop and remainder.
// Depends on pcg_pkg; drives request ready and response valid.
module pcg_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    output pcg_pkg::pcg_ctrl_t ctrl,
    input  pcg_pkg::pcg_stat_t stat,
    pcg_req_if.sink            req,
    pcg_rsp_if.source          rsp
);
    import pcg_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADV   = 3'd1;
    localparam logic [2:0] S_SEED  = 3'd2;
    localparam logic [2:0] S_THR   = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_REM   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam logic [CNT_W-1:0] ADV_LAST = CNT_W'(4);
    localparam logic [CNT_W-1:0] DIV_LAST = '1;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CMD_W-1:0] op_reg, op_next;
    logic             first_reg, first_next;
    logic [1:0]       src_reg, src_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        ctrl           = '0;
        ctrl.out_sel   = src_reg;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        first_next     = first_reg;
        src_next       = src_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = req.cmd;
                    cnt_next = '0;
                    unique case (req.cmd)
                        CMD_RESEED:
                        begin
                            ctrl.reseed_init = 1'b1;
                            first_next = 1'b1;
                            state_next = S_ADV;
                        end
                        CMD_RAW:
                            state_next = S_ADV;
                        CMD_BOUNDED:
                        begin
                            if (stat.bound_zero)
                            begin
                                src_next   = SRC_ZERO;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                ctrl.div_start_thr = 1'b1;
                                state_next = S_THR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ADV:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                unique case (cnt_reg)
                    CNT_W'(0):
                    begin
                        ctrl.word_capture = 1'b1;
                        ctrl.mul_en  = 1'b1;
                        ctrl.mul_sel = MUL_LL;
                    end
                    CNT_W'(1):
                    begin
                        ctrl.acc_load = 1'b1;
                        ctrl.mul_en   = 1'b1;
                        ctrl.mul_sel  = MUL_HL;
                    end
                    CNT_W'(2):
                    begin
                        ctrl.acc_add = 1'b1;
                        ctrl.mul_en  = 1'b1;
                        ctrl.mul_sel = MUL_LH;
                    end
                    CNT_W'(3):
                        ctrl.acc_add = 1'b1;
                    default:
                        ctrl.state_update = 1'b1;
                endcase
                if (cnt_reg == ADV_LAST)
                begin
                    cnt_next = '0;
                    priority if (op_reg == CMD_RESEED && first_reg)
                        state_next = S_SEED;
                    else if (op_reg == CMD_RESEED)
                        state_next = S_IDLE;
                    else if (op_reg == CMD_RAW)
                    begin
                        src_next   = SRC_WORD;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_CHECK;
                end
            end
            S_SEED:
            begin
                ctrl.seed_add = 1'b1;
                first_next = 1'b0;
                cnt_next   = '0;
                state_next = S_ADV;
            end
            S_THR:
            begin
                ctrl.div_step = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    ctrl.thr_capture = 1'b1;
                    state_next = S_ADV;
                end
            end
            S_CHECK:
            begin
                cnt_next = '0;
                if (stat.draw_ok)
                begin
                    ctrl.div_start_word = 1'b1;
                    state_next = S_REM;
                end
                else
                    state_next = S_ADV;
            end
            S_REM:
            begin
                ctrl.div_step = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    src_next   = SRC_REM;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold until the result register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    ctrl.out_load  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            op_reg        <= CMD_RAW;
            first_reg     <= 1'b0;
            src_reg       <= SRC_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            first_reg     <= first_next;
            src_reg       <= src_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/pcg32_xsh_rr_generator.sv =====
// PCG32 XSH-RR generator top level. One item at a time; each LCG advance
// runs on the shared 32x32 multiplier. A raw draw gives one result; a
// reseed gives no result. A bounded draw computes the threshold remainder,
// repeats draw attempts until one is accepted, then computes the result
// remainder; bound zero answers zero without any division. Reset clears state and increment
// to zero, seed to zero and stream select to its default. Depends on pcg_pkg, pcg_ifs.
module pcg32_xsh_rr_generator (
    input  logic      clk,
    input  logic      rst_n,
    pcg_req_if.sink   req,
    pcg_rsp_if.source rsp,
    pcg_cfg_if.sink   cfg
);
    import pcg_pkg::*;

    pcg_ctrl_t ctrl;
    pcg_stat_t stat;

    pcg_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp)
    );

    pcg_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

endmodule

// ===== tb/pcg32_xsh_rr_checker.sv =====
// Passive checker for the PCG32 XSH-RR generator: watches the request, response
// and register channels, predicts every result word and compares it in order.
// Depends on pcg_pkg and the channel interfaces in pcg_ifs.
module pcg32_xsh_rr_checker (
    input  logic        clk,
    input  logic        rst_n,
    pcg_req_if          req,
    pcg_rsp_if          rsp,
    pcg_cfg_if          cfg,
    output int unsigned error_count,
    output int unsigned outstanding,
    output int unsigned results_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import pcg_pkg::*;

    localparam logic [63:0] PCG_MULTIPLIER = 64'd6364136223846793005;
    localparam logic [62:0] STREAM_DEFAULT = 63'd1442695040888963407;

    logic [63:0] seed_reg;
    logic [62:0] stream_reg;
    logic [63:0] lcg_now;
    logic [63:0] lcg_inc;
    logic [31:0] pending_words[$];
    logic [31:0] want;

    // one LCG step; the output word comes from the state before the step
    function automatic logic [31:0] pcg_next_word();
        logic [63:0] prev;
        logic [31:0] folded;
        logic [4:0]  rot;
        prev    = lcg_now;
        lcg_now = prev * PCG_MULTIPLIER + lcg_inc;
        folded  = 32'(((prev >> 18) ^ prev) >> 27);
        rot     = prev[63:59];
        return (folded >> rot) | (folded << ((32 - int'(rot)) & 31));
    endfunction

    function automatic void expect_from_request(input logic [1:0] code,
                                                input logic [31:0] limit);
        logic [31:0] word;
        logic [31:0] floor_val;
        logic [63:0] prior;
        logic        done;
        case (code)
            CMD_RESEED:
            begin
                lcg_inc = {stream_reg, 1'b1};
                lcg_now = '0;
                void'(pcg_next_word());
                lcg_now = lcg_now + seed_reg;
                void'(pcg_next_word());
            end
            CMD_RAW:
            begin
                pending_words.push_back(pcg_next_word());
            end
            CMD_BOUNDED:
            begin
                if (limit == '0)
                begin
                    pending_words.push_back('0);
                end
                else
                begin
                    floor_val = (32'd0 - limit) % limit;
                    done = 1'b0;
                    while (!done)
                    begin
                        prior = lcg_now;
                        word  = pcg_next_word();
                        // a rejected draw that leaves the state unchanged is taken as is
                        done  = (word >= floor_val) || (lcg_now == prior);
                    end
                    pending_words.push_back(word % limit);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg        = '0;
            stream_reg      = STREAM_DEFAULT;
            lcg_now         = '0;
            lcg_inc         = '0;
            pending_words.delete();
            error_count     = 0;
            results_checked = 0;
            outstanding    <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_words.size() == 0)
                begin
                    $error("value: no result expected, actual %h", rsp.value);
                    error_count++;
                end
                else
                begin
                    want = pending_words.pop_front();
                    if (rsp.value !== want)
                    begin
                        $error("value mismatch: expected %h, actual %h", want, rsp.value);
                        error_count++;
                    end
                    results_checked++;
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_SEED: seed_reg   = cfg.data;
                    REG_SEQ:  stream_reg = cfg.data[62:0];
                    default:
                    begin
                    end
                endcase
            end
            if (req.valid && req.ready)
                expect_from_request(req.cmd, req.bound);
            outstanding <= pending_words.size();
        end
    end

endmodule

// ===== tb/tb_pcg32_xsh_rr_generator.sv =====
// Testbench top for the PCG32 XSH-RR generator: clock, reset, request and
// register stimulus, response back-pressure and the final verdict.
// Depends on pcg_pkg, pcg_ifs, the generator RTL and pcg32_xsh_rr_checker.
module tb_pcg32_xsh_rr_generator;
    timeunit 1ns;
    timeprecision 1ps;
    import pcg_pkg::*;

    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam int         SEG_ITEMS   = 209;
    localparam int         SETTLE_CYC  = 40;

    logic clk = 1'b0;
    logic rst_n;

    int unsigned error_count;
    int unsigned outstanding;
    int unsigned results_checked;

    int unsigned send_idle_pct;
    int unsigned rsp_stall_pct;
    int unsigned n_reseed;
    int unsigned n_raw;
    int unsigned n_bounded;
    int unsigned n_spare;
    int unsigned n_cfg;

    pcg_req_if req_ch ();
    pcg_rsp_if rsp_ch ();
    pcg_cfg_if cfg_ch ();

    pcg32_xsh_rr_generator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    pcg32_xsh_rr_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .cfg             (cfg_ch),
        .error_count     (error_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);

    task automatic send_item(input logic [1:0] code, input logic [31:0] limit);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= code;
        req_ch.bound <= limit;
        do @(posedge clk); while (!req_ch.ready);
        case (code)
            CMD_RESEED:  n_reseed++;
            CMD_RAW:     n_raw++;
            CMD_BOUNDED: n_bounded++;
            default:     n_spare++;
        endcase
    endtask

    task automatic set_config(input logic [63:0] seed, input logic [63:0] stream);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_SEED;
        cfg_ch.data  <= seed;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.index <= REG_SEQ;
        cfg_ch.data  <= stream;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        n_cfg += 2;
    endtask

    // all results in, then let a trailing reseed or ignored item finish
    task automatic wait_drain();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_bound();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 55)
            return $urandom_range(64, 1);
        else if (sel < 70)
            return $urandom;
        else if (sel < 80)
            return 32'h8000_0000 + $urandom_range(255);   // near half range: many rejections
        else if (sel < 88)
            return 32'd1 << $urandom_range(31);
        else if (sel < 94)
            return 32'hFFFF_FFFF - $urandom_range(15);
        else
            return '0;
    endfunction

    task automatic random_item(output logic [1:0] code);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5)
            code = CMD_RESEED;
        else if (pick < 45)
            code = CMD_RAW;
        else if (pick < 96)
            code = CMD_BOUNDED;
        else
            code = CMD_SPARE;
        send_item(code, pick_bound());
    endtask

    initial
    begin
        #4_000_000;
        $display("timeout: handshakes stopped before the run completed");
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int unsigned counted;
        logic [1:0]  code;
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.cmd    = CMD_RESEED;
        req_ch.bound  = '0;
        rsp_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = REG_SEED;
        cfg_ch.data   = '0;
        send_idle_pct = 34;
        rsp_stall_pct = 73;
        n_reseed = 0;
        n_raw = 0;
        n_bounded = 0;
        n_spare = 0;
        n_cfg = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero state before any reseed, including the stuck rejection
        send_item(CMD_RAW, '0);
        send_item(CMD_BOUNDED, 32'd5);
        send_item(CMD_BOUNDED, '0);
        send_item(CMD_SPARE, 32'hFFFF_FFFF);
        // default stream with zero seed
        send_item(CMD_RESEED, '0);
        send_item(CMD_RAW, 32'hFFFF_FFFF);
        send_item(CMD_BOUNDED, 32'd1);
        send_item(CMD_BOUNDED, 32'hFFFF_FFFF);
        send_item(CMD_BOUNDED, 32'h8000_0001);
        send_item(CMD_BOUNDED, 32'h8000_0000);
        send_item(CMD_BOUNDED, 32'd3);
        send_item(CMD_BOUNDED, '0);
        send_item(CMD_SPARE, '0);
        send_item(CMD_RAW, '0);
        wait_drain();
        // all-ones: top bit of the stream word must be dropped
        set_config('1, '1);
        send_item(CMD_RESEED, 32'hFFFF_FFFF);
        send_item(CMD_RAW, '0);
        send_item(CMD_BOUNDED, 32'd7);
        send_item(CMD_BOUNDED, 32'hFFFF_FFFE);
        wait_drain();
        set_config('0, '0);
        send_item(CMD_RESEED, '0);
        send_item(CMD_RAW, '0);
        send_item(CMD_BOUNDED, 32'd2);
        send_item(CMD_RAW, '0);

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 34;
                    rsp_stall_pct = 73;
                end
                1:
                begin
                    send_idle_pct = 73;
                    rsp_stall_pct = 34;
                end
                default:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 2; seg++)
            begin
                wait_drain();
                set_config({$urandom, $urandom}, {$urandom, $urandom});
                send_item(CMD_RESEED, $urandom);
                counted = 0;
                while (counted < SEG_ITEMS)
                begin
                    random_item(code);
                    if (code != CMD_SPARE)
                        counted++;
                end
            end
        end

        wait_drain();
        $display("Covered %0d reseeds, %0d raw and %0d bounded draws, %0d ignored codes,",
                 n_reseed, n_raw, n_bounded, n_spare);
        $display("%0d register writes, %0d results checked, %0d mismatches",
                 n_cfg, results_checked, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
